// ===== design/mclbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mclbt_pkg
// Shared types for the multi-channel LED blink timer: controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mclbt_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TICKS_W = 24;
  localparam int unsigned CHAN_W  = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef enum logic {
    MODE_TICK  = 1'b0,
    MODE_START = 1'b1
  } mode_t;

  typedef struct packed {
    logic start_wr;
    logic time_inc;
    logic walk_clr;
    logic walk_issue;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_last;
    logic out_free;
  } ctrl_status_t;

endpackage : mclbt_pkg
`default_nettype wire

// ===== design/multi_channel_led_blink_timer_unit.sv =====
// Tick item: one table read and one check per channel, pipelined through the
// channel walk, then a drain state before the result is loaded.
// Start item: the table write, then the result load. One item at a time; the
// next item is taken while the previous result waits in the output register.
// Synchronous reset clears time, channel flags, phases and levels; the
// per-channel tables are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_led_blink_timer_unit
// Bank of LED blink channels on a shared tick counter: start items arm a
// channel, tick items advance time and walk all channels.
// ----------------------------------------------------------------------------
module multi_channel_led_blink_timer_unit #(
  parameter int unsigned CHANNELS = 25
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          mode,
  input  wire logic [mclbt_pkg::CHAN_W-1:0]  channel,
  input  wire logic [mclbt_pkg::TICKS_W-1:0] interval_ticks,
  input  wire logic [mclbt_pkg::TICKS_W-1:0] duration_ticks,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [CHANNELS-1:0]                led_levels
);
  import mclbt_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  mclbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .cmd      (cmd),
    .status   (status)
  );

  mclbt_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .channel        (channel),
    .interval_ticks (interval_ticks),
    .duration_ticks (duration_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .led_levels     (led_levels)
  );

endmodule : multi_channel_led_blink_timer_unit
`default_nettype wire

// ===== design/mclbt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mclbt_ctrl
// Controller state machine: takes an item, sequences the channel walk for a
// tick and hands the levels to the output register.
// ----------------------------------------------------------------------------
module mclbt_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  mode,
  output mclbt_pkg::ctrl_cmd_t       cmd,
  input  wire mclbt_pkg::ctrl_status_t status
);
  import mclbt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (mode == MODE_START) begin
            cmd.start_wr = 1'b1;
            state_next   = ST_FINISH;
          end else begin
            cmd.time_inc = 1'b1;
            cmd.walk_clr = 1'b1;
            state_next   = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.walk_issue = 1'b1;
        if (status.walk_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule : mclbt_ctrl
`default_nettype wire

// ===== design/mclbt_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mclbt_dpath
// Datapath: time counter, per-channel tables, pipelined channel check
// (read one cycle, evaluate and write back the next) and output register.
// ----------------------------------------------------------------------------
module mclbt_dpath #(
  parameter int unsigned CHANNELS = 25
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire mclbt_pkg::ctrl_cmd_t             cmd,
  output mclbt_pkg::ctrl_status_t               status,
  input  wire logic [mclbt_pkg::CHAN_W-1:0]     channel,
  input  wire logic [mclbt_pkg::TICKS_W-1:0]    interval_ticks,
  input  wire logic [mclbt_pkg::TICKS_W-1:0]    duration_ticks,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [CHANNELS-1:0]                   led_levels
);
  import mclbt_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CMP_W = 7;

  logic [TIME_W-1:0]  time_now;
  logic [CHANNELS-1:0] active;
  logic [CHANNELS-1:0] phase;
  logic [CHANNELS-1:0] level;
  logic [CHANNELS-1:0] toggled;

  logic [TIME_W-1:0]  start_mem [CHANNELS];
  logic [TICKS_W-1:0] intv_mem  [CHANNELS];
  logic [TICKS_W-1:0] dur_mem   [CHANNELS];
  logic [TIME_W-1:0]  last_mem  [CHANNELS];

  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   eval_idx;
  logic               eval_vld;
  logic [TIME_W-1:0]  start_rd;
  logic [TICKS_W-1:0] intv_rd;
  logic [TICKS_W-1:0] dur_rd;
  logic [TIME_W-1:0]  last_rd;

  logic               ch_ok;
  logic [IDX_W-1:0]   wr_idx;
  logic [TIME_W-1:0]  since_start;
  logic [TIME_W-1:0]  since_toggle;
  logic [TIME_W-1:0]  last_val;
  logic               in_window;
  logic               do_toggle;

  assign ch_ok  = {{(CMP_W-CHAN_W){1'b0}}, channel} < CMP_W'(CHANNELS);
  assign wr_idx = IDX_W'(channel);

  assign status.walk_last = (rd_idx == IDX_W'(CHANNELS - 1));
  assign status.out_free  = !out_valid || out_ready;

  // time counter
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
    end else if (cmd.time_inc) begin
      time_now <= time_now + TIME_W'(1);
    end
  end

  // channel tables
  always_ff @(posedge clk) begin
    if (cmd.start_wr && ch_ok) begin
      start_mem[wr_idx] <= time_now;
      intv_mem[wr_idx]  <= interval_ticks;
      dur_mem[wr_idx]   <= duration_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_vld && do_toggle) begin
      last_mem[eval_idx] <= time_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_issue) begin
      start_rd <= start_mem[rd_idx];
      intv_rd  <= intv_mem[rd_idx];
      dur_rd   <= dur_mem[rd_idx];
      last_rd  <= last_mem[rd_idx];
    end
  end

  // walk sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      eval_vld <= 1'b0;
    end else begin
      eval_vld <= cmd.walk_issue;
      if (cmd.walk_clr) begin
        rd_idx <= '0;
      end else if (cmd.walk_issue && !status.walk_last) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_issue) begin
      eval_idx <= rd_idx;
    end
  end

  // channel check
  assign last_val     = toggled[eval_idx] ? last_rd : '0;
  assign since_start  = time_now - start_rd;
  assign since_toggle = time_now - last_val;
  assign in_window    = since_start < {{(TIME_W-TICKS_W){1'b0}}, dur_rd};
  assign do_toggle    = active[eval_idx] && in_window &&
                        (since_toggle > {{(TIME_W-TICKS_W){1'b0}}, intv_rd});

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= '0;
      phase   <= '0;
      level   <= '0;
      toggled <= '0;
    end else begin
      if (cmd.start_wr && ch_ok) begin
        active[wr_idx] <= 1'b1;
      end
      if (eval_vld && active[eval_idx]) begin
        if (do_toggle) begin
          phase[eval_idx]   <= !phase[eval_idx];
          level[eval_idx]   <= !phase[eval_idx];
          toggled[eval_idx] <= 1'b1;
        end else if (!in_window && !phase[eval_idx]) begin
          level[eval_idx] <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      led_levels <= level;
    end
  end

endmodule : mclbt_dpath
`default_nettype wire

// ===== design/mclbt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mclbt_checker
// Port-level checks for the blink timer, bound to the top level.
// ----------------------------------------------------------------------------
module mclbt_checker #(
  parameter int unsigned CHANNELS = 25
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          mode,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [CHANNELS-1:0]           led_levels
);
  import mclbt_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input taken again right after an item");

  // start item result is loaded from the finish state when the output is free
  a_start_latency: assert property (@(posedge clk) disable iff (rst)
    (in_acc && mode == MODE_START && !out_valid) |-> ##2 out_valid)
    else $error("start item result missing");

  // reset leaves no result
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(led_levels))
    else $error("result changed while stalled");

endmodule : mclbt_checker

bind multi_channel_led_blink_timer_unit mclbt_checker #(
  .CHANNELS (CHANNELS)
) u_mclbt_checker (.*);
`default_nettype wire
